// ----- hw/rtl/spfp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helpers of the signed packet field parser.
package spfp_pkg;

  // Fixed field and counter widths
  localparam int COUNT_W    = 24;
  localparam int OFFSET_W   = 20;
  localparam int TIME_W     = 64;
  localparam int LEN_W      = 32;
  localparam int MAXLEN_W   = 21;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 21;

  localparam int HEADER_BYTES = 8;
  localparam int MAGIC_BYTES  = 6;
  localparam int TIME_BYTES   = 8;
  localparam int LENF_BYTES   = 4;

  // Defaults for the layout parameters of the top level
  localparam int DEF_KEY_BYTES   = 32;
  localparam int DEF_MSGID_BYTES = 32;
  localparam int DEF_NAME_BYTES  = 128;
  localparam int DEF_SIG_BYTES   = 64;

  localparam logic [COUNT_W-1:0]  COUNT_MAX  = '1;
  localparam logic [OFFSET_W-1:0] OFFSET_MAX = '1;

  // Register reset values
  localparam logic [7:0]          RST_SIGNED_VERSION = 8'd2;
  localparam logic [7:0]          RST_ANNOUNCE_ID    = 8'd1;
  localparam logic [7:0]          RST_TEXT_ID        = 8'd2;
  localparam logic [MAXLEN_W-1:0] RST_MAX_TEXT_BYTES = 21'd1048576;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIGNED_VERSION = 2'd0,
    REG_ANNOUNCE_ID    = 2'd1,
    REG_TEXT_ID        = 2'd2,
    REG_MAX_TEXT_BYTES = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_UNKNOWN  = 2'd0,
    KIND_ANNOUNCE = 2'd1,
    KIND_TEXT     = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_SHORT    = 3'd1,
    ERR_MAGIC    = 3'd2,
    ERR_VERSION  = 3'd3,
    ERR_ID       = 3'd4,
    ERR_TOO_LONG = 3'd5,
    ERR_LEN      = 3'd6
  } error_t;

  typedef enum logic [3:0] {
    FLD_HEADER     = 4'd0,
    FLD_KEY        = 4'd1,
    FLD_VALID_FROM = 4'd2,
    FLD_MSGID      = 4'd3,
    FLD_AUTHOR     = 4'd4,
    FLD_TIME       = 4'd5,
    FLD_NAME       = 4'd6,
    FLD_LEN        = 4'd7,
    FLD_TEXT       = 4'd8,
    FLD_SIG        = 4'd9,
    FLD_EXCESS     = 4'd10
  } field_t;

  // Per-packet state seen by the field decoder
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    kind_t              kind;
    logic [LEN_W-1:0]   len;
  } track_state_t;

  // Outcome of one byte step
  typedef struct packed {
    kind_t             kind;
    error_t            err;
    logic              ok;
    logic [TIME_W-1:0] time_val;
    logic [LEN_W-1:0]  len;
  } verdict_t;

  // Expected magic byte at header position idx
  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    logic [7:0] val;
    case (idx)
      3'd0:    val = 8'h66;
      3'd1:    val = 8'h77;
      3'd2:    val = 8'h88;
      3'd3:    val = 8'h11;
      3'd4:    val = 8'h34;
      3'd5:    val = 8'h35;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

// ----- hw/rtl/spfp_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for packet bytes in and tagged bytes out.
interface spfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       end_of_packet;

  modport source (output valid, output byte_in, output end_of_packet, input ready);
  modport sink   (input valid, input byte_in, input end_of_packet, output ready);
endinterface

interface spfp_out_if;
  logic                          valid;
  logic                          ready;
  logic [7:0]                    byte_out;
  logic [3:0]                    field_code;
  logic [spfp_pkg::OFFSET_W-1:0] field_offset;
  logic                          packet_done;
  logic                          packet_ok;
  logic [1:0]                    packet_kind;
  logic [2:0]                    error_code;
  logic [spfp_pkg::TIME_W-1:0]   time_value;
  logic [spfp_pkg::LEN_W-1:0]    text_length;

  modport source (output valid, output byte_out, output field_code, output field_offset,
                  output packet_done, output packet_ok, output packet_kind,
                  output error_code, output time_value, output text_length, input ready);
  modport sink   (input valid, input byte_out, input field_code, input field_offset,
                  input packet_done, input packet_ok, input packet_kind,
                  input error_code, input time_value, input text_length, output ready);
endinterface

// ----- hw/rtl/spfp_field_decode.sv -----
`timescale 1ns / 1ps
// Field tag and in-field offset of the current byte from the packet position.
module spfp_field_decode #(
  parameter int KEY_BYTES   = spfp_pkg::DEF_KEY_BYTES,
  parameter int MSGID_BYTES = spfp_pkg::DEF_MSGID_BYTES,
  parameter int NAME_BYTES  = spfp_pkg::DEF_NAME_BYTES,
  parameter int SIG_BYTES   = spfp_pkg::DEF_SIG_BYTES
) (
  input  spfp_pkg::track_state_t          st,
  output spfp_pkg::field_t                code,
  output logic [spfp_pkg::OFFSET_W-1:0]   offset
);
  import spfp_pkg::*;

  localparam int SUM_W = LEN_W + 1;

  // Announcement layout boundaries
  localparam logic [COUNT_W-1:0] C_HDR_END  = COUNT_W'(HEADER_BYTES);
  localparam logic [COUNT_W-1:0] C_A_KEY    = COUNT_W'(HEADER_BYTES + KEY_BYTES);
  localparam logic [COUNT_W-1:0] C_A_VF     = COUNT_W'(HEADER_BYTES + KEY_BYTES + TIME_BYTES);
  localparam logic [COUNT_W-1:0] C_A_SIG    =
    COUNT_W'(HEADER_BYTES + KEY_BYTES + TIME_BYTES + SIG_BYTES);

  // Signed text layout boundaries
  localparam logic [COUNT_W-1:0] C_T_MSG    = COUNT_W'(HEADER_BYTES + MSGID_BYTES);
  localparam logic [COUNT_W-1:0] C_T_AUTH   = COUNT_W'(HEADER_BYTES + MSGID_BYTES + KEY_BYTES);
  localparam logic [COUNT_W-1:0] C_T_TIME   =
    COUNT_W'(HEADER_BYTES + MSGID_BYTES + KEY_BYTES + TIME_BYTES);
  localparam logic [COUNT_W-1:0] C_T_NAME   =
    COUNT_W'(HEADER_BYTES + MSGID_BYTES + KEY_BYTES + TIME_BYTES + NAME_BYTES);
  localparam logic [COUNT_W-1:0] C_T_LEN    =
    COUNT_W'(HEADER_BYTES + MSGID_BYTES + KEY_BYTES + TIME_BYTES + NAME_BYTES + LENF_BYTES);
  localparam logic [COUNT_W-1:0] C_SIG      = COUNT_W'(SIG_BYTES);

  logic [COUNT_W-1:0] p;
  logic [COUNT_W-1:0] rel;
  logic [SUM_W-1:0]   text_end;
  logic [COUNT_W-1:0] post_text;

  assign p = st.count;

  // End of the text field; past it the position is small enough to truncate
  assign text_end  = SUM_W'(C_T_LEN) + SUM_W'(st.len);
  assign post_text = p - text_end[COUNT_W-1:0];

  // Locate the byte in the layout of the packet kind
  always_comb begin
    code = FLD_EXCESS;
    rel  = '0;
    if (p < C_HDR_END) begin
      code = FLD_HEADER;
      rel  = p;
    end else begin
      case (st.kind)
        KIND_ANNOUNCE: begin
          if (p < C_A_KEY) begin
            code = FLD_KEY;
            rel  = p - C_HDR_END;
          end else if (p < C_A_VF) begin
            code = FLD_VALID_FROM;
            rel  = p - C_A_KEY;
          end else if (p < C_A_SIG) begin
            code = FLD_SIG;
            rel  = p - C_A_VF;
          end else begin
            code = FLD_EXCESS;
            rel  = p - C_A_SIG;
          end
        end
        KIND_TEXT: begin
          if (p < C_T_MSG) begin
            code = FLD_MSGID;
            rel  = p - C_HDR_END;
          end else if (p < C_T_AUTH) begin
            code = FLD_AUTHOR;
            rel  = p - C_T_MSG;
          end else if (p < C_T_TIME) begin
            code = FLD_TIME;
            rel  = p - C_T_AUTH;
          end else if (p < C_T_NAME) begin
            code = FLD_NAME;
            rel  = p - C_T_TIME;
          end else if (p < C_T_LEN) begin
            code = FLD_LEN;
            rel  = p - C_T_NAME;
          end else if (SUM_W'(p) < text_end) begin
            code = FLD_TEXT;
            rel  = p - C_T_LEN;
          end else if (post_text < C_SIG) begin
            code = FLD_SIG;
            rel  = post_text;
          end else begin
            code = FLD_EXCESS;
            rel  = post_text - C_SIG;
          end
        end
        default: begin
          code = FLD_EXCESS;
          rel  = p - C_HDR_END;
        end
      endcase
    end
  end

  // Saturate the offset
  assign offset = (|rel[COUNT_W-1:OFFSET_W]) ? OFFSET_MAX : rel[OFFSET_W-1:0];

endmodule

// ----- hw/rtl/spfp_track.sv -----
`timescale 1ns / 1ps
// Per-packet state: header checks, field assembly, byte count and final verdict.
module spfp_track #(
  parameter int KEY_BYTES   = spfp_pkg::DEF_KEY_BYTES,
  parameter int MSGID_BYTES = spfp_pkg::DEF_MSGID_BYTES,
  parameter int NAME_BYTES  = spfp_pkg::DEF_NAME_BYTES,
  parameter int SIG_BYTES   = spfp_pkg::DEF_SIG_BYTES
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            step,
  input  logic [7:0]                      byte_in,
  input  logic                            last,
  input  spfp_pkg::field_t                code,
  input  logic [7:0]                      signed_version,
  input  logic [7:0]                      announce_id,
  input  logic [7:0]                      text_id,
  input  logic [spfp_pkg::MAXLEN_W-1:0]   max_text_bytes,
  output spfp_pkg::track_state_t          st,
  output spfp_pkg::verdict_t              verdict
);
  import spfp_pkg::*;

  localparam int SUM_W      = LEN_W + 2;
  localparam int ANN_SIZE   = HEADER_BYTES + KEY_BYTES + TIME_BYTES + SIG_BYTES;
  localparam int FIXED_SIZE =
    HEADER_BYTES + MSGID_BYTES + KEY_BYTES + TIME_BYTES + NAME_BYTES + LENF_BYTES;

  // Header positions, and size checks on the position of the final byte (size minus one)
  localparam logic [COUNT_W-1:0] C_HDR_LAST  = COUNT_W'(HEADER_BYTES - 1);
  localparam logic [COUNT_W-1:0] C_HDR_END   = COUNT_W'(HEADER_BYTES);
  localparam logic [COUNT_W-1:0] C_MAGIC_END = COUNT_W'(MAGIC_BYTES);
  localparam logic [COUNT_W-1:0] C_VER_POS   = COUNT_W'(HEADER_BYTES - 2);
  localparam logic [COUNT_W-1:0] C_ANN_LAST  = COUNT_W'(ANN_SIZE - 1);
  localparam logic [COUNT_W-1:0] C_TXT_MIN   = COUNT_W'(FIXED_SIZE + SIG_BYTES - 1);
  localparam logic [SUM_W-1:0]   C_TXT_BASE  = SUM_W'(FIXED_SIZE + SIG_BYTES);

  logic [COUNT_W-1:0] count_r, count_nxt;
  kind_t              kind_r, kind_nxt;
  error_t             ferr_r, ferr_nxt;
  logic [TIME_W-1:0]  time_r, time_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  error_t             hdr_err;
  error_t             err;
  logic [SUM_W-1:0]   txt_total;
  logic [SUM_W-1:0]   pkt_total;

  // Check the header byte and classify by the id byte
  always_comb begin
    hdr_err  = ERR_NONE;
    kind_nxt = kind_r;
    if (count_r < C_MAGIC_END) begin
      if (byte_in != magic_byte(count_r[2:0])) hdr_err = ERR_MAGIC;
    end else if (count_r == C_VER_POS) begin
      if (byte_in != signed_version) hdr_err = ERR_VERSION;
    end else if (count_r < C_HDR_END) begin
      if (byte_in == announce_id) begin
        kind_nxt = KIND_ANNOUNCE;
      end else if (byte_in == text_id) begin
        kind_nxt = KIND_TEXT;
      end else begin
        kind_nxt = KIND_UNKNOWN;
        hdr_err  = ERR_ID;
      end
    end
  end

  // Keep the first header fault only
  assign ferr_nxt = (ferr_r == ERR_NONE) ? hdr_err : ferr_r;

  // Shift in timestamp and length bytes big-endian
  assign time_nxt = (code == FLD_VALID_FROM || code == FLD_TIME) ?
                    {time_r[TIME_W-9:0], byte_in} : time_r;
  assign len_nxt  = (code == FLD_LEN) ? {len_r[LEN_W-9:0], byte_in} : len_r;

  assign count_nxt = (count_r == COUNT_MAX) ? count_r : count_r + COUNT_W'(1);

  assign txt_total = C_TXT_BASE + SUM_W'(len_nxt);
  assign pkt_total = SUM_W'(count_r) + SUM_W'(1);

  // Verdict on the final byte in check order
  always_comb begin
    err = ERR_NONE;
    if (last) begin
      if (count_r < C_HDR_LAST) begin
        err = ERR_SHORT;
      end else if (ferr_nxt != ERR_NONE) begin
        err = ferr_nxt;
      end else begin
        case (kind_nxt)
          KIND_ANNOUNCE: begin
            if (count_r < C_ANN_LAST)       err = ERR_SHORT;
            else if (count_r != C_ANN_LAST) err = ERR_LEN;
          end
          KIND_TEXT: begin
            if (count_r < C_TXT_MIN)                     err = ERR_SHORT;
            else if (len_nxt > LEN_W'(max_text_bytes))   err = ERR_TOO_LONG;
            else if (txt_total != pkt_total)             err = ERR_LEN;
          end
          default: err = ERR_ID;
        endcase
      end
    end
  end

  assign verdict.kind     = kind_nxt;
  assign verdict.err      = err;
  assign verdict.ok       = last && (err == ERR_NONE);
  assign verdict.time_val = time_nxt;
  assign verdict.len      = len_nxt;

  assign st.count = count_r;
  assign st.kind  = kind_r;
  assign st.len   = len_r;

  // Advance per byte; drop all packet state after the final byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      kind_r  <= KIND_UNKNOWN;
      ferr_r  <= ERR_NONE;
      time_r  <= '0;
      len_r   <= '0;
    end else if (step) begin
      if (last) begin
        count_r <= '0;
        kind_r  <= KIND_UNKNOWN;
        ferr_r  <= ERR_NONE;
        time_r  <= '0;
        len_r   <= '0;
      end else begin
        count_r <= count_nxt;
        kind_r  <= kind_nxt;
        ferr_r  <= ferr_nxt;
        time_r  <= time_nxt;
        len_r   <= len_nxt;
      end
    end
  end

endmodule

// ----- hw/rtl/signed_packet_field_parser.sv -----
`timescale 1ns / 1ps
// A byte taken into the input register moves on to the result register once that is free.
// Throughput: one byte per cycle while the result channel is ready; the packet state
//   registers are updated in a single pass.
// An input register and a result register decouple the two channels.
// Reset (synchronous, rst_n low) clears packet state and channel valids, and loads the
//   config registers with their default values.
module signed_packet_field_parser #(
  parameter int KEY_BYTES   = spfp_pkg::DEF_KEY_BYTES,
  parameter int MSGID_BYTES = spfp_pkg::DEF_MSGID_BYTES,
  parameter int NAME_BYTES  = spfp_pkg::DEF_NAME_BYTES,
  parameter int SIG_BYTES   = spfp_pkg::DEF_SIG_BYTES
) (
  input  logic                              clk,
  input  logic                              rst_n,
  spfp_in_if.sink                           in_ch,
  spfp_out_if.source                        out_ch,
  input  logic                              cfg_wr_en,
  input  logic [spfp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [spfp_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import spfp_pkg::*;

  // Configuration registers
  logic [7:0]          signed_version_r;
  logic [7:0]          announce_id_r;
  logic [7:0]          text_id_r;
  logic [MAXLEN_W-1:0] max_text_bytes_r;

  // Input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;

  // Result register
  logic                out_valid_r;
  logic [7:0]          out_byte_r;
  field_t              out_code_r;
  logic [OFFSET_W-1:0] out_offset_r;
  logic                out_done_r;
  logic                out_ok_r;
  kind_t               out_kind_r;
  error_t              out_err_r;
  logic [TIME_W-1:0]   out_time_r;
  logic [LEN_W-1:0]    out_len_r;

  logic                out_free;
  logic                s1_go;
  track_state_t        trk_st;
  verdict_t            trk_verdict;
  field_t              dec_code;
  logic [OFFSET_W-1:0] dec_offset;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_go       = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || s1_go;

  // Hold register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      signed_version_r <= RST_SIGNED_VERSION;
      announce_id_r    <= RST_ANNOUNCE_ID;
      text_id_r        <= RST_TEXT_ID;
      max_text_bytes_r <= RST_MAX_TEXT_BYTES;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_SIGNED_VERSION: signed_version_r <= cfg_data[7:0];
        REG_ANNOUNCE_ID:    announce_id_r    <= cfg_data[7:0];
        REG_TEXT_ID:        text_id_r        <= cfg_data[7:0];
        REG_MAX_TEXT_BYTES: max_text_bytes_r <= cfg_data[MAXLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture an input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte_r <= in_ch.byte_in;
      s1_last_r <= in_ch.end_of_packet;
    end
  end

  spfp_field_decode #(
    .KEY_BYTES   (KEY_BYTES),
    .MSGID_BYTES (MSGID_BYTES),
    .NAME_BYTES  (NAME_BYTES),
    .SIG_BYTES   (SIG_BYTES)
  ) u_decode (
    .st     (trk_st),
    .code   (dec_code),
    .offset (dec_offset)
  );

  spfp_track #(
    .KEY_BYTES   (KEY_BYTES),
    .MSGID_BYTES (MSGID_BYTES),
    .NAME_BYTES  (NAME_BYTES),
    .SIG_BYTES   (SIG_BYTES)
  ) u_track (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (s1_go),
    .byte_in        (s1_byte_r),
    .last           (s1_last_r),
    .code           (dec_code),
    .signed_version (signed_version_r),
    .announce_id    (announce_id_r),
    .text_id        (text_id_r),
    .max_text_bytes (max_text_bytes_r),
    .st             (trk_st),
    .verdict        (trk_verdict)
  );

  // Load the result register; drop valid once the result is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_byte_r   <= s1_byte_r;
      out_code_r   <= dec_code;
      out_offset_r <= dec_offset;
      out_done_r   <= s1_last_r;
      out_ok_r     <= trk_verdict.ok;
      out_kind_r   <= trk_verdict.kind;
      out_err_r    <= trk_verdict.err;
      out_time_r   <= trk_verdict.time_val;
      out_len_r    <= trk_verdict.len;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.byte_out     = out_byte_r;
  assign out_ch.field_code   = out_code_r;
  assign out_ch.field_offset = out_offset_r;
  assign out_ch.packet_done  = out_done_r;
  assign out_ch.packet_ok    = out_ok_r;
  assign out_ch.packet_kind  = out_kind_r;
  assign out_ch.error_code   = out_err_r;
  assign out_ch.time_value   = out_time_r;
  assign out_ch.text_length  = out_len_r;

`ifndef SYNTH
  // Verdict is consistent with the error code on the final byte
  a_done_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.packet_done |-> (out_ch.packet_ok == (out_ch.error_code == ERR_NONE)))
    else $error("packet_ok disagrees with error_code");

  // No verdict before the final byte
  a_mid_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.packet_done |-> !out_ch.packet_ok && out_ch.error_code == ERR_NONE)
    else $error("verdict shown on a non-final byte");

  // Packet state restarts after the final byte
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && s1_last_r |=> trk_st.count == '0 && trk_st.len == '0 && trk_st.kind == KIND_UNKNOWN)
    else $error("packet state not cleared after final byte");
`endif

endmodule

// ----- test/spfp_tag_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the packet field parser: predicts each tagged byte and compares it.
module spfp_tag_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  spfp_in_if                              in_ch,
  spfp_out_if                             out_ch,
  input  logic                            cfg_wr_en,
  input  logic [spfp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [spfp_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              pending
);
  import spfp_pkg::*;

  // Layout sizes of the instance under test (default parameters)
  localparam longint unsigned KEY_N   = DEF_KEY_BYTES;
  localparam longint unsigned MSGID_N = DEF_MSGID_BYTES;
  localparam longint unsigned NAME_N  = DEF_NAME_BYTES;
  localparam longint unsigned SIG_N   = DEF_SIG_BYTES;
  localparam longint unsigned ANN_SIZE = HEADER_BYTES + KEY_N + TIME_BYTES + SIG_N;
  localparam longint unsigned FIXED_SIZE =
    HEADER_BYTES + MSGID_N + KEY_N + TIME_BYTES + NAME_N + LENF_BYTES;
  localparam int REPORT_MAX = 10;

  localparam logic [7:0] MAGIC_SEQ [MAGIC_BYTES] = '{8'h66, 8'h77, 8'h88, 8'h11, 8'h34, 8'h35};

  typedef struct packed {
    logic [7:0]        data;
    field_t            field;
    logic [OFFSET_W-1:0] offset;
    logic              done;
    logic              ok;
    kind_t             kind;
    error_t            err;
    logic [TIME_W-1:0] tstamp;
    logic [LEN_W-1:0]  tlen;
  } byte_tag_t;

  // Register copies
  logic [7:0]          cfg_version;
  logic [7:0]          cfg_announce;
  logic [7:0]          cfg_text;
  logic [MAXLEN_W-1:0] cfg_max;

  // Per-packet state
  logic [COUNT_W-1:0] pos;
  kind_t              cur_kind;
  error_t             first_err;
  logic [TIME_W-1:0]  ts_acc;
  logic [LEN_W-1:0]   len_acc;

  byte_tag_t tag_queue [$];

  // Tag one byte, advance the packet state and give the verdict on the final byte
  function automatic byte_tag_t parse_byte(input logic [7:0] b, input logic last);
    byte_tag_t       t;
    longint unsigned p, q, base, off, total;
    longint unsigned t1, t2, t3, t4, t5, t6, t7;
    field_t          fld;
    error_t          err;
    p    = 64'(pos);
    err  = ERR_NONE;
    base = 0;
    if (p < HEADER_BYTES) begin
      fld = FLD_HEADER;
      off = p;
      if (p < MAGIC_BYTES) begin
        if (b != MAGIC_SEQ[p[2:0]]) err = ERR_MAGIC;
      end else if (p == HEADER_BYTES - 2) begin
        if (b != cfg_version) err = ERR_VERSION;
      end else if (b == cfg_announce) begin
        cur_kind = KIND_ANNOUNCE;
      end else if (b == cfg_text) begin
        cur_kind = KIND_TEXT;
      end else begin
        cur_kind = KIND_UNKNOWN;
        err      = ERR_ID;
      end
      if (err != ERR_NONE && first_err == ERR_NONE) first_err = err;
      err = ERR_NONE;
    end else begin
      q = p - HEADER_BYTES;
      case (cur_kind)
        KIND_ANNOUNCE: begin
          if (q < KEY_N) begin
            fld = FLD_KEY;
          end else if (q < KEY_N + TIME_BYTES) begin
            fld = FLD_VALID_FROM; base = KEY_N;
          end else if (q < KEY_N + TIME_BYTES + SIG_N) begin
            fld = FLD_SIG; base = KEY_N + TIME_BYTES;
          end else begin
            fld = FLD_EXCESS; base = KEY_N + TIME_BYTES + SIG_N;
          end
        end
        KIND_TEXT: begin
          t1 = MSGID_N;
          t2 = t1 + KEY_N;
          t3 = t2 + TIME_BYTES;
          t4 = t3 + NAME_N;
          t5 = t4 + LENF_BYTES;
          t6 = t5 + len_acc;
          t7 = t6 + SIG_N;
          if (q < t1) begin
            fld = FLD_MSGID;
          end else if (q < t2) begin
            fld = FLD_AUTHOR; base = t1;
          end else if (q < t3) begin
            fld = FLD_TIME; base = t2;
          end else if (q < t4) begin
            fld = FLD_NAME; base = t3;
          end else if (q < t5) begin
            fld = FLD_LEN; base = t4;
          end else if (q < t6) begin
            fld = FLD_TEXT; base = t5;
          end else if (q < t7) begin
            fld = FLD_SIG; base = t6;
          end else begin
            fld = FLD_EXCESS; base = t7;
          end
        end
        default: fld = FLD_EXCESS;
      endcase
      off = q - base;
    end

    // Shift in the big-endian time and length fields
    if (fld == FLD_VALID_FROM || fld == FLD_TIME) ts_acc = {ts_acc[TIME_W-9:0], b};
    if (fld == FLD_LEN) len_acc = {len_acc[LEN_W-9:0], b};
    if (off > OFFSET_MAX) off = OFFSET_MAX;
    if (pos != COUNT_MAX) pos = pos + 1'b1;

    // Verdict in the order short, header faults, then size checks per kind
    if (last) begin
      total = p + 1;
      if (total < HEADER_BYTES) begin
        err = ERR_SHORT;
      end else if (first_err != ERR_NONE) begin
        err = first_err;
      end else if (cur_kind == KIND_ANNOUNCE) begin
        if (total < ANN_SIZE) err = ERR_SHORT;
        else if (total != ANN_SIZE) err = ERR_LEN;
      end else if (cur_kind == KIND_TEXT) begin
        if (total < FIXED_SIZE + SIG_N) err = ERR_SHORT;
        else if (len_acc > cfg_max) err = ERR_TOO_LONG;
        else if (FIXED_SIZE + len_acc + SIG_N != total) err = ERR_LEN;
      end else begin
        err = ERR_ID;
      end
    end

    t.data   = b;
    t.field  = fld;
    t.offset = off[OFFSET_W-1:0];
    t.done   = last;
    t.ok     = last && (err == ERR_NONE);
    t.kind   = cur_kind;
    t.err    = err;
    t.tstamp = ts_acc;
    t.tlen   = len_acc;

    if (last) begin
      pos       = '0;
      cur_kind  = KIND_UNKNOWN;
      first_err = ERR_NONE;
      ts_acc    = '0;
      len_acc   = '0;
    end
    return t;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= REPORT_MAX)
        $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    byte_tag_t want;
    if (!rst_n) begin
      cfg_version  = RST_SIGNED_VERSION;
      cfg_announce = RST_ANNOUNCE_ID;
      cfg_text     = RST_TEXT_ID;
      cfg_max      = RST_MAX_TEXT_BYTES;
      pos          = '0;
      cur_kind     = KIND_UNKNOWN;
      first_err    = ERR_NONE;
      ts_acc       = '0;
      len_acc      = '0;
      tag_queue.delete();
      pending <= 0;
    end else begin
      // Compare a result transfer against the oldest prediction
      if (out_ch.valid && out_ch.ready) begin
        if (tag_queue.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("%0t: result with nothing expected, byte %0h", $realtime,
                     out_ch.byte_out);
        end else begin
          want = tag_queue.pop_front();
          check_field("byte_out", 64'(want.data), 64'(out_ch.byte_out));
          check_field("field_code", 64'(want.field), 64'(out_ch.field_code));
          check_field("field_offset", 64'(want.offset), 64'(out_ch.field_offset));
          check_field("packet_done", 64'(want.done), 64'(out_ch.packet_done));
          check_field("packet_ok", 64'(want.ok), 64'(out_ch.packet_ok));
          check_field("packet_kind", 64'(want.kind), 64'(out_ch.packet_kind));
          check_field("error_code", 64'(want.err), 64'(out_ch.error_code));
          check_field("time_value", want.tstamp, out_ch.time_value);
          check_field("text_length", 64'(want.tlen), 64'(out_ch.text_length));
        end
      end

      // Predict every byte transfer
      if (in_ch.valid && in_ch.ready)
        tag_queue.push_back(parse_byte(in_ch.byte_in, in_ch.end_of_packet));

      // Track register writes
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_SIGNED_VERSION: cfg_version  = cfg_data[7:0];
          REG_ANNOUNCE_ID:    cfg_announce = cfg_data[7:0];
          REG_TEXT_ID:        cfg_text     = cfg_data[7:0];
          REG_MAX_TEXT_BYTES: cfg_max      = cfg_data[MAXLEN_W-1:0];
          default: ;
        endcase
      end
      pending <= tag_queue.size();
    end
  end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// Top of the packet parser testbench: clock, reset, packet stimulus and the verdict.
module testbench;
  import spfp_pkg::*;

  localparam int STALL_PCT   = 22;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 4;
  localparam int KEY_N   = DEF_KEY_BYTES;
  localparam int MSGID_N = DEF_MSGID_BYTES;
  localparam int NAME_N  = DEF_NAME_BYTES;
  localparam int SIG_N   = DEF_SIG_BYTES;

  localparam logic [7:0] MAGIC_SEQ [MAGIC_BYTES] = '{8'h66, 8'h77, 8'h88, 8'h11, 8'h34, 8'h35};

  typedef enum int {SHP_ANNOUNCE, SHP_TEXT, SHP_UNKNOWN, SHP_NOISE} shape_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    tags_pending;
  int                    quiet_cycles;
  bit                    calm;

  // Register values as last written, used to build well-formed headers
  logic [7:0]          cur_version;
  logic [7:0]          cur_announce;
  logic [7:0]          cur_text;
  logic [MAXLEN_W-1:0] cur_max;

  logic [7:0] pkt [$];

  spfp_in_if  in_ch ();
  spfp_out_if out_ch ();

  signed_packet_field_parser dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  spfp_tag_checker tag_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (tags_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall the result channel at random, except in calm stretches
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= calm || ($urandom_range(99) >= STALL_PCT);
    end
  end

  // End the run when no transfer happens for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic bit take_gap();
    return !calm && ($urandom_range(99) < STALL_PCT);
  endfunction

  task automatic send_byte(input logic [7:0] data, input logic last);
    if (take_gap()) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while (take_gap());
    end
    in_ch.valid         <= 1'b1;
    in_ch.byte_in       <= data;
    in_ch.end_of_packet <= last;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_packet();
    foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
  endtask

  // Drop valid, wait until every result is back, then hold for HOLD_CYCLES
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (tags_pending != 0) @(posedge clk);
    repeat (HOLD_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] version, input logic [7:0] announce,
                            input logic [7:0] text, input logic [MAXLEN_W-1:0] max_len);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_SIGNED_VERSION;
    cfg_data  <= CFG_DATA_W'(version);
    @(posedge clk);
    cfg_index <= REG_ANNOUNCE_ID;
    cfg_data  <= CFG_DATA_W'(announce);
    @(posedge clk);
    cfg_index <= REG_TEXT_ID;
    cfg_data  <= CFG_DATA_W'(text);
    @(posedge clk);
    cfg_index <= REG_MAX_TEXT_BYTES;
    cfg_data  <= CFG_DATA_W'(max_len);
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    cur_version  = version;
    cur_announce = announce;
    cur_text     = text;
    cur_max      = max_len;
  endtask

  function automatic void push_header(input logic [7:0] id);
    foreach (MAGIC_SEQ[i]) pkt.push_back(MAGIC_SEQ[i]);
    pkt.push_back(cur_version);
    pkt.push_back(id);
  endfunction

  function automatic void push_noise(input int n);
    repeat (n) pkt.push_back(8'($urandom()));
  endfunction

  // Build one packet: mostly well-formed layouts, some broken on purpose
  function automatic void build_packet(input shape_t shape);
    int unsigned tlen;
    int          body, pick, cut;
    logic [7:0]  id;
    pkt.delete();
    case (shape)
      SHP_ANNOUNCE: begin
        push_header(cur_announce);
        push_noise(KEY_N + TIME_BYTES + SIG_N);
      end
      SHP_TEXT: begin
        pick = $urandom_range(99);
        body = $urandom_range(24);
        if (pick < 50) begin
          tlen = body;
        end else if (pick < 62) begin
          // declared length right at the limit
          tlen = 32'(cur_max);
          if (cur_max <= 40) body = int'(cur_max);
        end else if (pick < 74) begin
          tlen = 32'(cur_max) + 1 + $urandom_range(2);
        end else if (pick < 84) begin
          tlen = $urandom();
        end else begin
          // text shorter or longer than declared
          tlen = body;
          if (body > 0 && $urandom_range(1)) body = body - 1;
          else body = body + $urandom_range(1, 3);
        end
        push_header(cur_text);
        push_noise(MSGID_N + KEY_N + TIME_BYTES + NAME_N);
        pkt.push_back(tlen[31:24]);
        pkt.push_back(tlen[23:16]);
        pkt.push_back(tlen[15:8]);
        pkt.push_back(tlen[7:0]);
        push_noise(body + SIG_N);
      end
      SHP_UNKNOWN: begin
        do id = 8'($urandom_range(255)); while (id == cur_announce || id == cur_text);
        push_header(id);
        push_noise($urandom_range(40));
      end
      default: push_noise($urandom_range(1, 30));
    endcase

    // Corrupt, truncate or extend some of the structured packets
    if (shape == SHP_ANNOUNCE || shape == SHP_TEXT) begin
      if ($urandom_range(99) < 10) begin
        cut = $urandom_range(HEADER_BYTES - 1);
        pkt[cut] = pkt[cut] ^ 8'($urandom_range(1, 255));
      end
      pick = $urandom_range(99);
      if (pick < 18) begin
        cut = $urandom_range(1, pkt.size() - 1);
        while (pkt.size() > cut) void'(pkt.pop_back());
      end else if (pick < 26) begin
        push_noise($urandom_range(1, 5));
      end
    end
  endfunction

  task automatic run_phase(input int min_bytes, input int min_packets);
    int     sent, packets, pick;
    shape_t shape;
    sent    = 0;
    packets = 0;
    while (sent < min_bytes || packets < min_packets) begin
      pick = $urandom_range(99);
      if (pick < 38) shape = SHP_TEXT;
      else if (pick < 72) shape = SHP_ANNOUNCE;
      else if (pick < 86) shape = SHP_UNKNOWN;
      else shape = SHP_NOISE;
      build_packet(shape);
      send_packet();
      sent    += pkt.size();
      packets += 1;
    end
  endtask

  initial begin
    rst_n               <= 1'b0;
    cfg_wr_en           <= 1'b0;
    cfg_index           <= REG_SIGNED_VERSION;
    cfg_data            <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.byte_in       <= '0;
    in_ch.end_of_packet <= 1'b0;
    cur_version  = RST_SIGNED_VERSION;
    cur_announce = RST_ANNOUNCE_ID;
    cur_text     = RST_TEXT_ID;
    cur_max      = RST_MAX_TEXT_BYTES;
    calm         = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Lone byte: shorter than the header
    pkt.delete();
    pkt.push_back(8'hFF);
    send_packet();
    // Bad magic
    pkt.delete();
    push_header(cur_text);
    pkt[0] = 8'h00;
    send_packet();
    // Bad version; the id byte still sets the kind
    pkt.delete();
    push_header(cur_text);
    pkt[HEADER_BYTES - 2] = cur_version ^ 8'h80;
    send_packet();
    // Unknown id
    pkt.delete();
    push_header(8'h00);
    send_packet();

    run_phase(150, 1);

    // Low version and announce id, top text id, zero text limit
    settle();
    set_config(8'h00, 8'h00, 8'hFF, '0);
    run_phase(150, 1);

    // Equal ids, limit at the top of its range, no stalls on either side
    settle();
    calm = 1'b1;
    set_config(8'hFF, 8'h07, 8'h07, '1);
    run_phase(150, 1);

    settle();
    calm = 1'b0;
    set_config(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
               MAXLEN_W'($urandom_range(30)));
    run_phase(150, 1);

    settle();
    set_config(RST_SIGNED_VERSION, RST_ANNOUNCE_ID, RST_TEXT_ID, RST_MAX_TEXT_BYTES);
    run_phase(150, 1);

    settle();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
